// ----- src/swls_pkg.sv -----
// Shared constants and types for the sliding window latency statistics block.
package swls_pkg;

    localparam int WINDOW_DEPTH_DEF = 16;
    localparam int METRIC_SLOTS_DEF = 8;
    localparam int ORIGIN_SLOTS_DEF = 4;

    localparam logic [31:0] CPS_RESET = 32'd32768;
    localparam logic [19:0] US_PER_SEC = 20'd1000000;
    localparam int P95_NUM = 95;
    // Multiplying by 5243 and shifting right by 19 divides by 100 exactly over the rank range.
    localparam int P95_RECIP = 5243;
    localparam int P95_SHIFT = 19;
    localparam logic [31:0] P95_MUL = 32'(P95_NUM * P95_RECIP);

    localparam logic [1:0] MODE_REC_US  = 2'd0;
    localparam logic [1:0] MODE_REC_CYC = 2'd1;
    localparam logic [1:0] MODE_QUERY   = 2'd2;

    localparam logic [0:0] REG_CPS = 1'b0;

    typedef struct packed {
        logic        go;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

endpackage

// ----- src/swls_div.sv -----
// Sequential restoring divider, one quotient bit per cycle.
module swls_div (
    input  logic                clk,
    input  logic                rst_n,
    input  swls_pkg::div_req_t  req,
    output swls_pkg::div_rsp_t  rsp
);

    logic [63:0] quo_reg;
    logic [63:0] quo_next;
    logic [64:0] rem_reg;
    logic [64:0] rem_next;
    logic [63:0] den_reg;
    logic [6:0]  cnt_reg;
    logic [6:0]  cnt_next;
    logic        busy_reg;
    logic        busy_next;
    logic        done_reg;
    logic        done_next;
    logic [64:0] shifted;
    logic [64:0] diff;

    assign shifted = {rem_reg[63:0], quo_reg[63]};
    assign diff    = shifted - {1'b0, den_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.go)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[64])
            begin
                rem_next = diff;
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (req.go)
        begin
            den_reg <= req.divisor;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ----- src/sliding_window_latency_stats_top.sv -----
// Top level of the sliding window latency statistics block.
//
// Channel   Direction  Handshake             Payload
// config    in         psel/penable/pwrite   paddr, pwdata, prdata
// command   in         start and not busy    mode, metric, source, value
// result    out        strobe, one cycle     valid_res .. held_count
//
// An in-range microsecond record keeps busy high through states PUSHR, PUSHL and PUSHW,
// a cycle record also through CONV, which waits on the 64-step divider.
// A query keeps busy high while it reads the window, ranks each sample against all
// others and divides the sum.
// An out-of-range query goes straight to output; ignored records and mode 3 keep busy low.
// Reset clears the per-slot registers; results cannot be stalled.
module sliding_window_latency_stats_top #(
    parameter int WINDOW_DEPTH = swls_pkg::WINDOW_DEPTH_DEF,
    parameter int METRIC_SLOTS = swls_pkg::METRIC_SLOTS_DEF,
    parameter int ORIGIN_SLOTS = swls_pkg::ORIGIN_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [3:0]  metric,
    input  logic [3:0]  source,
    input  logic [31:0] value,
    output logic        strobe,
    output logic        valid_res,
    output logic [31:0] newest_us,
    output logic [31:0] min_us,
    output logic [31:0] max_us,
    output logic [31:0] avg_us,
    output logic [31:0] p95_us,
    output logic [4:0]  held_count
);

    localparam int SLOTS = METRIC_SLOTS * ORIGIN_SLOTS;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PW    = $clog2(WINDOW_DEPTH);
    localparam int CW    = $clog2(WINDOW_DEPTH + 1);
    localparam int SUMW  = 32 + CW;
    localparam int AW    = SW + PW;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_CONV  = 11'b00000000010,
        ST_PUSHR = 11'b00000000100,
        ST_PUSHW = 11'b00000001000,
        ST_QLOAD = 11'b00000010000,
        ST_QRANK = 11'b00000100000,
        ST_QDIV  = 11'b00001000000,
        ST_QWAIT = 11'b00010000000,
        ST_OUT   = 11'b00100000000,
        ST_PUSHL = 11'b01000000000,
        ST_QRD   = 11'b10000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [31:0] cps_reg;

    // Per-slot state registers with reset.
    logic [CW-1:0]   fill_reg  [SLOTS];
    logic [PW-1:0]   wp_reg    [SLOTS];
    logic [31:0]     newest_reg[SLOTS];
    logic [SUMW-1:0] sum_reg   [SLOTS];

    logic [31:0] mem [2**AW];
    logic [31:0] mem_rd_reg;
    logic [AW-1:0] mem_raddr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;

    logic [SW-1:0]   slot_reg;
    logic [31:0]     val_reg;
    logic            range_reg;
    logic [CW-1:0]   cnt_reg;
    logic [PW-1:0]   idx_reg;
    logic [PW-1:0]   jdx_reg;
    logic            rd_pend_reg;
    logic [PW-1:0]   ld_idx_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [31:0]     buf_reg [WINDOW_DEPTH];
    logic [31:0]     mn_reg;
    logic [31:0]     mx_reg;
    logic [31:0]     p95_reg;
    logic [CW-1:0]   less_reg;
    logic [CW-1:0]   leq_reg;
    logic [CW-1:0]   rank_c;
    logic [31:0]     avg_reg;
    logic            strobe_reg;

    swls_pkg::div_req_t dreq;
    swls_pkg::div_rsp_t drsp;

    logic accept;
    logic in_range;
    logic [SW-1:0] slot_c;
    logic [31:0]   start_sum;
    logic [PW-1:0] start_ptr;
    logic [31:0]   rank_full;

    assign accept   = start && !busy;
    assign in_range = (32'(metric) < 32'(METRIC_SLOTS)) && (32'(source) < 32'(ORIGIN_SLOTS));
    assign slot_c   = SW'(32'(metric) * 32'(ORIGIN_SLOTS) + 32'(source));
    assign start_sum = 32'(wp_reg[slot_reg]) + 32'(WINDOW_DEPTH) - 32'(fill_reg[slot_reg]);
    assign start_ptr = PW'((start_sum >= 32'(WINDOW_DEPTH)) ? start_sum - 32'(WINDOW_DEPTH)
                                                            : start_sum);
    assign rank_full = (32'(cnt_reg - CW'(1)) * swls_pkg::P95_MUL) >> swls_pkg::P95_SHIFT;
    assign rank_c   = CW'(rank_full);

    swls_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (dreq),
        .rsp  (drsp)
    );

    always_comb
    begin
        dreq = '0;
        if (state_reg == ST_CONV && !rd_pend_reg)
        begin
            dreq.go       = 1'b1;
            dreq.dividend = 64'(val_reg) * 64'(swls_pkg::US_PER_SEC);
            dreq.divisor  = 64'(cps_reg);
        end
        else if (state_reg == ST_QDIV)
        begin
            dreq.go       = 1'b1;
            dreq.dividend = 64'(sum_reg[slot_reg]);
            dreq.divisor  = 64'(cnt_reg);
        end
    end

    assign mem_raddr = {slot_reg, (state_reg == ST_PUSHR || state_reg == ST_PUSHL)
                                  ? wp_reg[slot_reg] : rd_ptr_reg};
    assign mem_we    = (state_reg == ST_PUSHW);
    assign mem_waddr = {slot_reg, wp_reg[slot_reg]};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= val_reg;
        end
        mem_rd_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode == swls_pkg::MODE_REC_US)
                    begin
                        state_next = in_range ? ST_PUSHR : ST_IDLE;
                    end
                    else if (mode == swls_pkg::MODE_REC_CYC)
                    begin
                        state_next = in_range ? ST_CONV : ST_IDLE;
                    end
                    else if (mode == swls_pkg::MODE_QUERY)
                    begin
                        state_next = ST_QRD;
                    end
                end
            end
            ST_CONV:  state_next = (rd_pend_reg && drsp.done) ? ST_PUSHR : ST_CONV;
            ST_PUSHR: state_next = ST_PUSHL;
            ST_PUSHL: state_next = ST_PUSHW;
            ST_PUSHW: state_next = ST_IDLE;
            ST_QRD:
            begin
                if (!range_reg || fill_reg[slot_reg] == '0)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_QLOAD;
                end
            end
            ST_QLOAD: state_next = (rd_pend_reg && ld_idx_reg == PW'(cnt_reg - CW'(1)))
                                   ? ST_QRANK : ST_QLOAD;
            ST_QRANK: state_next = (idx_reg == PW'(cnt_reg - CW'(1))
                                    && jdx_reg == PW'(cnt_reg - CW'(1))) ? ST_QDIV : ST_QRANK;
            ST_QDIV:  state_next = ST_QWAIT;
            ST_QWAIT: state_next = drsp.done ? ST_OUT : ST_QWAIT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cps_reg     <= swls_pkg::CPS_RESET;
            strobe_reg  <= 1'b0;
            rd_pend_reg <= 1'b0;
            for (int s = 0; s < SLOTS; s++)
            begin
                fill_reg[s]   <= '0;
                wp_reg[s]     <= '0;
                newest_reg[s] <= '0;
                sum_reg[s]    <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= (state_reg == ST_OUT);
            if (psel && penable && pwrite && paddr == swls_pkg::REG_CPS)
            begin
                cps_reg <= pwdata;
            end
            if (state_reg == ST_CONV)
            begin
                rd_pend_reg <= !(rd_pend_reg && drsp.done);
            end
            else if (state_reg == ST_QLOAD)
            begin
                rd_pend_reg <= 1'b1;
            end
            else
            begin
                rd_pend_reg <= 1'b0;
            end
            if (state_reg == ST_PUSHW)
            begin
                if (fill_reg[slot_reg] == CW'(WINDOW_DEPTH))
                begin
                    sum_reg[slot_reg] <= sum_reg[slot_reg] - SUMW'(mem_rd_reg) + SUMW'(val_reg);
                end
                else
                begin
                    fill_reg[slot_reg] <= fill_reg[slot_reg] + CW'(1);
                    sum_reg[slot_reg]  <= sum_reg[slot_reg] + SUMW'(val_reg);
                end
                wp_reg[slot_reg]     <= PW'(32'(wp_reg[slot_reg]) + 1 == WINDOW_DEPTH
                                        ? 0 : 32'(wp_reg[slot_reg]) + 1);
                newest_reg[slot_reg] <= val_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg  <= slot_c;
            val_reg   <= value;
            range_reg <= in_range;
        end
        if (state_reg == ST_CONV && rd_pend_reg && drsp.done)
        begin
            val_reg <= (cps_reg == '0) ? 32'd0 : drsp.quotient[31:0];
        end
        if (state_reg == ST_QRD)
        begin
            cnt_reg    <= fill_reg[slot_reg];
            ld_idx_reg <= '0;
            rd_ptr_reg <= start_ptr;
            mn_reg     <= '1;
            mx_reg     <= '0;
        end
        if (state_reg == ST_QLOAD)
        begin
            rd_ptr_reg <= PW'(32'(rd_ptr_reg) + 1 == WINDOW_DEPTH ? 0 : 32'(rd_ptr_reg) + 1);
            if (rd_pend_reg)
            begin
                buf_reg[ld_idx_reg] <= mem_rd_reg;
                if (mem_rd_reg < mn_reg)
                begin
                    mn_reg <= mem_rd_reg;
                end
                if (mem_rd_reg > mx_reg)
                begin
                    mx_reg <= mem_rd_reg;
                end
                ld_idx_reg <= ld_idx_reg + PW'(1);
            end
            idx_reg  <= '0;
            jdx_reg  <= '0;
            less_reg <= '0;
            leq_reg  <= '0;
        end
        if (state_reg == ST_QRANK)
        begin
            // The sample with fewer than rank+1 smaller and at least rank+1
            // smaller-or-equal entries sits at that rank in sorted order.
            priority if (jdx_reg == PW'(cnt_reg - CW'(1)))
            begin
                if ((less_reg + CW'(buf_reg[jdx_reg] < buf_reg[idx_reg])) <= rank_c
                    && (leq_reg + CW'(buf_reg[jdx_reg] <= buf_reg[idx_reg])) > rank_c)
                begin
                    p95_reg <= buf_reg[idx_reg];
                end
                jdx_reg  <= '0;
                idx_reg  <= idx_reg + PW'(1);
                less_reg <= '0;
                leq_reg  <= '0;
            end
            else
            begin
                less_reg <= less_reg + CW'(buf_reg[jdx_reg] < buf_reg[idx_reg]);
                leq_reg  <= leq_reg + CW'(buf_reg[jdx_reg] <= buf_reg[idx_reg]);
                jdx_reg  <= jdx_reg + PW'(1);
            end
        end
        if (state_reg == ST_QWAIT && drsp.done)
        begin
            avg_reg <= drsp.quotient[31:0];
        end
        if (state_reg == ST_OUT)
        begin
            if (!range_reg || fill_reg[slot_reg] == '0)
            begin
                valid_res  <= 1'b0;
                newest_us  <= '0;
                min_us     <= '0;
                max_us     <= '0;
                avg_us     <= '0;
                p95_us     <= '0;
                held_count <= '0;
            end
            else
            begin
                valid_res  <= 1'b1;
                newest_us  <= newest_reg[slot_reg];
                min_us     <= mn_reg;
                max_us     <= mx_reg;
                avg_us     <= avg_reg;
                p95_us     <= p95_reg;
                held_count <= 5'(cnt_reg);
            end
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign pready = 1'b1;
    assign prdata = (paddr == swls_pkg::REG_CPS) ? cps_reg : 32'd0;

`ifndef SYNTHESIS
    a_strobe_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |=> strobe)
        else $error("result strobe missing after output state");
    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (state_reg == ST_IDLE))
        else $error("strobe while still working");
    a_accept_query: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode == swls_pkg::MODE_QUERY) |=> (state_reg == ST_QRD))
        else $error("query not started");
`endif

endmodule
